/* src/hdc_pkg.sv */
package hdc_pkg;

  // payload capacity and derived sizes
  localparam int unsigned PAYLOAD_DEPTH = 1024;
  localparam int unsigned FRAME_DEPTH   = PAYLOAD_DEPTH + 2;
  localparam int unsigned CNT_W         = $clog2(FRAME_DEPTH + 1);
  localparam int unsigned LEN_W         = $clog2(PAYLOAD_DEPTH + 1);
  localparam int unsigned OFF_W         = $clog2(FRAME_DEPTH);
  localparam int unsigned RAM_AW        = OFF_W + 1;
  localparam int unsigned RAM_DEPTH     = 2 ** RAM_AW;
  localparam int unsigned FLEN_W        = 11;

  // line codes
  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_MASK  = 8'h20;

  // crc-16, msb first
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;

  // request kinds
  localparam logic CMD_FEED = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [1:0] {
    MODE_OUT = 2'd0,
    MODE_IN  = 2'd1,
    MODE_ESC = 2'd2
  } mode_e;

  function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* src/hdc_ram.sv */
module hdc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/hdlc_deframer_crc16_check.sv */
// channel   signals                                     direction
// request   in_valid_i / in_ready_o, command_i,         in
//           line_byte_i
// result    out_valid_o / out_ready_i, frame_ready_o,   out
//           frame_length_o, read_byte_o, read_valid_o,
//           read_last_o
//
// one request per cycle while out_ready_i stays high; each gives exactly one result,
// registered in the request stage with the buffer read, then in the output register
// reset clears parser mode, counters, crc and both valid flags; no clearing pass
// a full output register holds the request stage, and a held request stage drops
// in_ready_o; ready follows out_ready_i combinationally, valid never waits on it
module hdlc_deframer_crc16_check (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      command_i,
  input  logic [7:0]                line_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      frame_ready_o,
  output logic [hdc_pkg::FLEN_W-1:0] frame_length_o,
  output logic [7:0]                read_byte_o,
  output logic                      read_valid_o,
  output logic                      read_last_o
);

  import hdc_pkg::*;

  // result fields that do not come from the buffer memory
  typedef struct packed {
    logic              frame_ready;
    logic [FLEN_W-1:0] frame_length;
    logic              read_valid;
    logic              read_last;
  } res_t;

  // parser and staging state
  mode_e             mode_q, mode_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [15:0]       crc_q, crc_d;
  logic [7:0]        hist0_q, hist0_d;   // newest stored byte
  logic [7:0]        hist1_q, hist1_d;   // the one before it
  logic              rx_bank_q, rx_bank_d;
  logic              stg_bank_q, stg_bank_d;
  logic [LEN_W-1:0]  stg_len_q, stg_len_d;
  logic [LEN_W-1:0]  rd_off_q, rd_off_d;

  // pipeline
  logic              s1_valid_q;
  res_t              s1_q;
  res_t              s1_d;
  logic              out_valid_q;
  res_t              out_q;
  logic [7:0]        out_byte_q;

  logic              s1_adv;
  logic              acc;
  logic              feed_en;
  logic              rd_en;
  logic              read_hit;

  // byte decode
  logic              do_open;
  logic              do_esc;
  logic              do_data;
  logic              do_check;
  logic [7:0]        data_byte;
  logic              fits;
  logic              do_store;
  logic              do_abort;
  logic              crc_ok;
  logic              do_stage;
  logic [CNT_W-1:0]  plen;

  logic [RAM_AW-1:0] waddr;
  logic [RAM_AW-1:0] raddr;
  logic [7:0]        rdata;

  // handshake: the request stage moves on whenever the output register frees up
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign acc        = in_valid_i && in_ready_o;
  assign feed_en    = acc && (command_i == CMD_FEED);
  assign read_hit   = rd_off_q < stg_len_q;
  assign rd_en      = acc && (command_i == CMD_READ) && read_hit;

  // classify the line byte against the parser mode
  always_comb begin
    do_open   = 1'b0;
    do_esc    = 1'b0;
    do_data   = 1'b0;
    do_check  = 1'b0;
    data_byte = line_byte_i;
    unique case (mode_q)
      MODE_IN: begin
        if (line_byte_i == FLAG_BYTE) begin
          do_check = 1'b1;
          do_open  = 1'b1;
        end else if (line_byte_i == ESC_BYTE) begin
          do_esc = 1'b1;
        end else begin
          do_data = 1'b1;
        end
      end
      MODE_ESC: begin
        // escaped byte is data even when it is a flag
        do_data   = 1'b1;
        data_byte = line_byte_i ^ ESC_MASK;
      end
      default: begin
        if (line_byte_i == FLAG_BYTE) begin
          do_open = 1'b1;
        end
      end
    endcase
  end

  assign fits     = count_q < CNT_W'(FRAME_DEPTH);
  assign do_store = do_data && fits;
  assign do_abort = do_data && !fits;

  // the running crc trails the newest stored byte by two, so at the closing flag
  // it covers the payload and the two history bytes hold the received crc
  assign plen     = count_q - CNT_W'(2);
  assign crc_ok   = (count_q >= CNT_W'(3)) && ({hist1_q, hist0_q} == crc_q);
  assign do_stage = do_check && crc_ok;

  // next parser mode
  always_comb begin
    mode_d = mode_q;
    if (feed_en) begin
      if (do_open || do_store) begin
        mode_d = MODE_IN;
      end else if (do_esc) begin
        mode_d = MODE_ESC;
      end else begin
        // overflow abort, or a non-flag byte while out of frame
        mode_d = MODE_OUT;
      end
    end
  end

  // counters, crc, history and bank swap
  always_comb begin
    count_d    = count_q;
    crc_d      = crc_q;
    hist0_d    = hist0_q;
    hist1_d    = hist1_q;
    rx_bank_d  = rx_bank_q;
    stg_bank_d = stg_bank_q;
    stg_len_d  = stg_len_q;
    rd_off_d   = rd_off_q;
    if (feed_en) begin
      if (do_open || do_abort) begin
        count_d = '0;
        crc_d   = CRC_INIT;
      end
      if (do_store) begin
        if (count_q >= CNT_W'(2)) begin
          crc_d = crc_fold(crc_q, hist1_q);
        end
        hist1_d = hist0_q;
        hist0_d = data_byte;
        count_d = count_q + CNT_W'(1);
      end
      if (do_stage) begin
        // the receive bank becomes the staged bank: no copy needed
        stg_bank_d = rx_bank_q;
        rx_bank_d  = ~rx_bank_q;
        stg_len_d  = LEN_W'(plen);
        rd_off_d   = '0;
      end
    end
    if (rd_en) begin
      rd_off_d = rd_off_q + LEN_W'(1);
    end
  end

  // result fields known at accept time
  always_comb begin
    s1_d              = '0;
    s1_d.frame_ready  = feed_en && do_stage;
    s1_d.frame_length = (feed_en && do_stage) ? FLEN_W'(plen) : '0;
    s1_d.read_valid   = rd_en;
    s1_d.read_last    = rd_en && ((rd_off_q + LEN_W'(1)) == stg_len_q);
  end

  // one memory holds both banks; writes go to the receive bank, reads to the
  // staged bank, so a read never meets a write to the same entry
  assign waddr = {rx_bank_q, OFF_W'(count_q)};
  assign raddr = {stg_bank_q, OFF_W'(rd_off_q)};

  hdc_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (feed_en && do_store),
    .waddr_i (waddr),
    .wdata_i (data_byte),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_OUT;
      count_q     <= '0;
      crc_q       <= CRC_INIT;
      rx_bank_q   <= 1'b0;
      stg_bank_q  <= 1'b1;
      stg_len_q   <= '0;
      rd_off_q    <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      count_q    <= count_d;
      crc_q      <= crc_d;
      rx_bank_q  <= rx_bank_d;
      stg_bank_q <= stg_bank_d;
      stg_len_q  <= stg_len_d;
      rd_off_q   <= rd_off_d;
      if (in_ready_o) begin
        s1_valid_q <= acc;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // payload registers; the memory holds its read data while the request stage
  // is held, since no new read is issued then
  always_ff @(posedge clk_i) begin
    hist0_q <= hist0_d;
    hist1_q <= hist1_d;
    if (acc) begin
      s1_q <= s1_d;
    end
    if (s1_adv && s1_valid_q) begin
      out_q      <= s1_q;
      out_byte_q <= s1_q.read_valid ? rdata : 8'h00;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_ready_o  = out_q.frame_ready;
  assign frame_length_o = out_q.frame_length;
  assign read_byte_o    = out_byte_q;
  assign read_valid_o   = out_q.read_valid;
  assign read_last_o    = out_q.read_last;

endmodule

/* tb/sv/testbench.sv */
module testbench;
  import hdc_pkg::*;

  // one result per request, fields as the block drives them
  typedef struct packed {
    logic              frame_ready;
    logic [FLEN_W-1:0] frame_length;
    logic [7:0]        read_byte;
    logic              read_valid;
    logic              read_last;
  } result_t;

  // one row of the directed table; typed rows carry their own answer
  typedef struct packed {
    logic    cmd;
    logic [7:0] line;
    bit      typed;
    result_t res;
  } dir_row_t;

  localparam result_t R_NONE = '0;
  localparam int unsigned DIR_ROWS = 24;
  localparam int unsigned HOLD_CYCLES = 300;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              command_i;
  logic [7:0]        line_byte_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              frame_ready_o;
  logic [FLEN_W-1:0] frame_length_o;
  logic [7:0]        read_byte_o;
  logic              read_valid_o;
  logic              read_last_o;

  hdlc_deframer_crc16_check u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .line_byte_i    (line_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_ready_o  (frame_ready_o),
    .frame_length_o (frame_length_o),
    .read_byte_o    (read_byte_o),
    .read_valid_o   (read_valid_o),
    .read_last_o    (read_last_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // expected results in request order, and run-wide flags
  result_t     pending_results[$];
  int unsigned mismatch_cnt = 0;
  int unsigned n_sent = 0;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;

  // ---------------------------------------------------------------------------
  // receiver mirror: parser, frame store, crc and staged payload
  // ---------------------------------------------------------------------------
  mode_e       rx_mode = MODE_OUT;
  logic [7:0]  frame_mem [FRAME_DEPTH];
  int unsigned frame_cnt = 0;
  logic [15:0] rx_crc = CRC_INIT;
  logic [7:0]  stage_mem [PAYLOAD_DEPTH];
  int unsigned stage_len = 0;
  int unsigned rd_ptr = 0;

  // msb-first crc-16, one bit of data at a time
  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] data);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[15] ^ data[i];
      crc = {crc[14:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  function automatic void open_rx();
    frame_cnt = 0;
    rx_crc    = CRC_INIT;
    rx_mode   = MODE_IN;
  endfunction

  // crc trails the newest stored byte by two, so at close it covers the payload
  function automatic void store_rx(logic [7:0] b);
    if (frame_cnt < FRAME_DEPTH) begin
      if (frame_cnt >= 2) begin
        rx_crc = crc16_step(rx_crc, frame_mem[frame_cnt-2]);
      end
      frame_mem[frame_cnt] = b;
      frame_cnt++;
      rx_mode = MODE_IN;
    end else begin
      // overflow: abort, drop bytes until the next flag
      frame_cnt = 0;
      rx_crc    = CRC_INIT;
      rx_mode   = MODE_OUT;
    end
  endfunction

  function automatic result_t deframe_step(logic cmd, logic [7:0] b);
    result_t     r;
    int unsigned plen;
    logic [15:0] got;
    r = '0;
    if (cmd == CMD_FEED) begin
      case (rx_mode)
        MODE_IN: begin
          if (b == FLAG_BYTE) begin
            // short frames and crc mismatches leave the staged payload alone
            if (frame_cnt >= 3) begin
              plen = frame_cnt - 2;
              got  = {frame_mem[plen], frame_mem[plen+1]};
              if (got == rx_crc && plen <= PAYLOAD_DEPTH) begin
                for (int unsigned k = 0; k < plen; k++) begin
                  stage_mem[k] = frame_mem[k];
                end
                stage_len      = plen;
                rd_ptr         = 0;
                r.frame_ready  = 1'b1;
                r.frame_length = FLEN_W'(plen);
              end
            end
            open_rx();
          end else if (b == ESC_BYTE) begin
            rx_mode = MODE_ESC;
          end else begin
            store_rx(b);
          end
        end
        MODE_ESC: begin
          // a flag right after an escape is plain data
          store_rx(b ^ ESC_MASK);
        end
        default: begin
          if (b == FLAG_BYTE) begin
            open_rx();
          end else begin
            rx_mode = MODE_OUT;
          end
        end
      endcase
    end else if (rd_ptr < stage_len) begin
      r.read_byte  = stage_mem[rd_ptr];
      r.read_valid = 1'b1;
      r.read_last  = (rd_ptr + 1 == stage_len);
      rd_ptr++;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // offer one request, optionally after an idle burst; predict on acceptance
  task automatic offer_request(input logic cmd, input logic [7:0] b, input bit typed,
                               input result_t fixed);
    result_t pred;
    if (!no_idle && $urandom_range(0, 11) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    line_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    pred = deframe_step(cmd, b);
    pending_results.push_back(typed ? fixed : pred);
    n_sent++;
  endtask

  task automatic feed_req(input logic [7:0] b);
    offer_request(CMD_FEED, b, 1'b0, R_NONE);
  endtask

  // the line byte of a read request is don't-care, so it is random
  task automatic read_req();
    offer_request(CMD_READ, 8'($urandom_range(0, 255)), 1'b0, R_NONE);
  endtask

  // stop offering until every expected result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // payload plus big-endian crc, stuffed, closed by a flag; bad flips one bit
  task automatic send_frame(input int unsigned len, input bit bad);
    logic [7:0]  body[$];
    logic [7:0]  b;
    logic [15:0] c;
    int unsigned pos;
    body = {};
    c    = CRC_INIT;
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        b = $urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE;
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      body.push_back(b);
      c = crc16_step(c, b);
    end
    body.push_back(c[15:8]);
    body.push_back(c[7:0]);
    if (bad) begin
      pos       = $urandom_range(0, body.size() - 1);
      body[pos] = body[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
    // opening flag when needed, sometimes a redundant one (empty short frame)
    if (rx_mode != MODE_IN || $urandom_range(0, 3) == 0) begin
      feed_req(FLAG_BYTE);
    end
    foreach (body[i]) begin
      // flag and escape must be stuffed, other bytes sometimes are
      if (body[i] == FLAG_BYTE || body[i] == ESC_BYTE || $urandom_range(0, 15) == 0) begin
        feed_req(ESC_BYTE);
        feed_req(body[i] ^ ESC_MASK);
      end else begin
        feed_req(body[i]);
      end
    end
    feed_req(FLAG_BYTE);
  endtask

  // directed requests: reset read, out-of-frame bytes, short frame, the
  // "123456789" check frame (crc 0x29b1), an escaped flag and a bad crc
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{CMD_READ, 8'h00,     1'b1, R_NONE},
    '{CMD_FEED, 8'h00,     1'b1, R_NONE},
    '{CMD_FEED, ESC_BYTE,  1'b1, R_NONE},
    '{CMD_FEED, FLAG_BYTE, 1'b1, R_NONE},
    '{CMD_FEED, FLAG_BYTE, 1'b1, R_NONE},
    '{CMD_FEED, 8'h31,     1'b0, R_NONE},
    '{CMD_FEED, 8'h32,     1'b0, R_NONE},
    '{CMD_FEED, 8'h33,     1'b0, R_NONE},
    '{CMD_FEED, 8'h34,     1'b0, R_NONE},
    '{CMD_FEED, 8'h35,     1'b0, R_NONE},
    '{CMD_FEED, 8'h36,     1'b0, R_NONE},
    '{CMD_FEED, 8'h37,     1'b0, R_NONE},
    '{CMD_FEED, 8'h38,     1'b0, R_NONE},
    '{CMD_FEED, 8'h39,     1'b0, R_NONE},
    '{CMD_FEED, 8'h29,     1'b0, R_NONE},
    '{CMD_FEED, 8'hB1,     1'b0, R_NONE},
    '{CMD_FEED, FLAG_BYTE, 1'b1, '{1'b1, 11'd9, 8'h00, 1'b0, 1'b0}},
    '{CMD_READ, 8'hFF,     1'b1, '{1'b0, 11'd0, 8'h31, 1'b1, 1'b0}},
    '{CMD_FEED, ESC_BYTE,  1'b0, R_NONE},
    '{CMD_FEED, FLAG_BYTE, 1'b0, R_NONE},
    '{CMD_FEED, 8'hFF,     1'b0, R_NONE},
    '{CMD_FEED, 8'h00,     1'b0, R_NONE},
    '{CMD_FEED, FLAG_BYTE, 1'b1, R_NONE},
    '{CMD_READ, 8'h00,     1'b1, '{1'b0, 11'd0, 8'h32, 1'b1, 1'b0}}
  };

  // ---------------------------------------------------------------------------
  // result side: check against the oldest expectation, then pick ready
  // ---------------------------------------------------------------------------
  initial begin
    result_t     want;
    int unsigned stall_left;
    stall_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result with no request pending");
          mismatch_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (frame_ready_o !== want.frame_ready) begin
            $error("frame_ready expected %0d got %0d", want.frame_ready, frame_ready_o);
            mismatch_cnt++;
          end
          if (frame_length_o !== want.frame_length) begin
            $error("frame_length expected %0d got %0d", want.frame_length, frame_length_o);
            mismatch_cnt++;
          end
          if (read_byte_o !== want.read_byte) begin
            $error("read_byte expected %h got %h", want.read_byte, read_byte_o);
            mismatch_cnt++;
          end
          if (read_valid_o !== want.read_valid) begin
            $error("read_valid expected %0d got %0d", want.read_valid, read_valid_o);
            mismatch_cnt++;
          end
          if (read_last_o !== want.read_last) begin
            $error("read_last expected %0d got %0d", want.read_last, read_last_o);
            mismatch_cnt++;
          end
        end
      end
      // long hold-off on request, counted here
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(1, 17) - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned pick;
    int unsigned len;
    bit          hold_done;
    bit          pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    command_i   <= CMD_FEED;
    line_byte_i <= 8'h00;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      offer_request(dir_tab[i].cmd, dir_tab[i].line, dir_tab[i].typed, dir_tab[i].res);
    end

    // random: mostly well-formed frames, with bad crc, reads, noise and
    // broken sequences mixed in
    while (n_sent < 120) begin
      if (!hold_done && n_sent >= 40) begin
        // receiver stalls while requests keep coming, so the block backs up
        hold_done = 1'b1;
        hold_req  = 1'b1;
      end
      if (!pause_done && n_sent >= 80) begin
        pause_done = 1'b1;
        wait_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
        send_frame(len, 1'b0);
        // sometimes drain past the end to hit read_last and empty reads
        if ($urandom_range(0, 1) == 1) begin
          repeat ($urandom_range(1, len + 2)) read_req();
        end
      end else if (pick < 70) begin
        send_frame($urandom_range(1, 12), 1'b1);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 12)) read_req();
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 8)) begin
          offer_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, R_NONE);
        end
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            // short frame, fewer than three stored bytes
            feed_req(FLAG_BYTE);
            repeat ($urandom_range(0, 2)) feed_req(8'($urandom_range(0, 8'h7C)));
            feed_req(FLAG_BYTE);
          end
          1: begin
            // escape before flag: stores an escaped flag, frame goes on
            feed_req(ESC_BYTE);
            feed_req(FLAG_BYTE);
          end
          default: begin
            send_frame(0, 1'b0);
          end
        endcase
      end
    end

    // last part, no idling: a frame that fills the store and overflows
    no_idle = 1'b1;
    feed_req(FLAG_BYTE);
    repeat (FRAME_DEPTH + 1) feed_req(8'($urandom_range(0, 8'h7C)));
    // out of frame now: these are dropped
    feed_req(ESC_BYTE);
    feed_req(8'hFF);
    repeat (2) read_req();
    send_frame(3, 1'b0);
    repeat (5) read_req();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("hdlc_deframer_crc16_check test passed");
    end else begin
      $display("hdlc_deframer_crc16_check test failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20000000;
    $display("hdlc_deframer_crc16_check test failed");
    $finish;
  end

endmodule
